// ===== design/ops_pkg.sv =====
// ----------------------------------------------------------------------------
// ops_pkg
// Shared widths, constants, datapath opcodes and the command/status
// structs that join the sieve controller and datapath.
// ----------------------------------------------------------------------------
package ops_pkg;

  localparam int LIMIT_W       = 21;
  localparam int VALUE_W       = 20;
  localparam int RESET_LIMIT   = 1000000;
  localparam int DEF_MAX_LIMIT = 1048576;

  // one memory word holds the marks of 32 consecutive odd numbers (64 integers)
  localparam int MARK_W  = 32;
  localparam int BIT_W   = 5;
  localparam int WORD_SH = 6;

  localparam int OP_W = 4;
  localparam logic [OP_W-1:0] OP_NOP         = 4'd0;
  localparam logic [OP_W-1:0] OP_CLR_START   = 4'd1;
  localparam logic [OP_W-1:0] OP_CLR_STEP    = 4'd2;
  localparam logic [OP_W-1:0] OP_FROM3       = 4'd3;
  localparam logic [OP_W-1:0] OP_FIND_RD     = 4'd4;
  localparam logic [OP_W-1:0] OP_FIND_CHK    = 4'd5;
  localparam logic [OP_W-1:0] OP_SQ          = 4'd6;
  localparam logic [OP_W-1:0] OP_STRIKE_INIT = 4'd7;
  localparam logic [OP_W-1:0] OP_STRIKE_RD   = 4'd8;
  localparam logic [OP_W-1:0] OP_STRIKE_WR   = 4'd9;
  localparam logic [OP_W-1:0] OP_NEXT_P      = 4'd10;
  localparam logic [OP_W-1:0] OP_REQ_INIT    = 4'd11;
  localparam logic [OP_W-1:0] OP_EMIT_NONE   = 4'd12;
  localparam logic [OP_W-1:0] OP_EMIT_HIT    = 4'd13;
  localparam logic [OP_W-1:0] OP_EMIT_MISS   = 4'd14;
  localparam logic [OP_W-1:0] OP_BUILD_DONE  = 4'd15;

  typedef struct packed {
    logic [OP_W-1:0] op;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic from_ge_lim;
    logic chk_hit;
    logic chk_none;
    logic sq_lt_lim;
    logic m_ge_lim;
    logic two_pend;
    logic exh;
    logic lim_le2;
  } sts_t;

endpackage

// ===== design/ops_dp.sv =====
// ----------------------------------------------------------------------------
// ops_dp
// Sieve datapath: composite-mark memory, search and strike registers,
// limit register, scan state and result registers.
// ----------------------------------------------------------------------------
module ops_dp import ops_pkg::*; #(
  parameter int MAX_LIMIT = DEF_MAX_LIMIT
) (
  input  logic               clk,
  input  logic               rst_n,
  input  cmd_t               cmd,
  output sts_t               sts,
  input  logic               cfg_we,
  input  logic [LIMIT_W-1:0] cfg_upper_limit,
  output logic               out_strobe,
  output logic [VALUE_W-1:0] out_prime_value,
  output logic               out_valid_res,
  output logic               out_last
);

  localparam int NW      = ($clog2(MAX_LIMIT) + 2 > LIMIT_W + 1) ?
                           $clog2(MAX_LIMIT) + 2 : LIMIT_W + 1;
  localparam int WORDS   = (MAX_LIMIT / 2 + MARK_W - 1) / MARK_W;
  localparam int AW      = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int LIM_RST = (RESET_LIMIT > MAX_LIMIT) ? MAX_LIMIT : RESET_LIMIT;

  logic [MARK_W-1:0] mem [WORDS];
  logic [MARK_W-1:0] rd_data_r;

  logic [NW-1:0]   lim_r, lim_nxt;
  logic [AW-1:0]   addr_r;
  logic [NW-1:0]   from_r;
  logic [NW-1:0]   p_r;
  logic [NW-1:0]   m_r;
  logic [2*NW-1:0] sq_r;
  logic [NW-1:0]   e_r;
  logic [NW-1:0]   next_r;
  logic            two_pend_r;
  logic            exh_r;
  logic            strobe_r;
  logic [VALUE_W-1:0] prime_r;
  logic            valid_r;
  logic            last_r;

  logic [AW-1:0]     rd_addr;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [MARK_W-1:0] wr_data;
  logic [MARK_W-1:0] low_mask;
  logic [MARK_W-1:0] masked;
  logic              zero_found;
  logic [BIT_W-1:0]  zero_idx;
  logic [NW-1:0]     cand;
  logic [AW-1:0]     from_word;
  logic [AW-1:0]     m_word;
  logic [AW-1:0]     clr_end;
  logic              lim_le2;

  assign from_word = AW'(from_r >> WORD_SH);
  assign m_word    = AW'(m_r >> WORD_SH);
  assign lim_le2   = (lim_r <= NW'(2));
  assign clr_end   = lim_le2 ? '0 : AW'((lim_r - NW'(1)) >> WORD_SH);
  assign lim_nxt   = (NW'(cfg_upper_limit) > NW'(MAX_LIMIT)) ?
                     NW'(MAX_LIMIT) : NW'(cfg_upper_limit);

  assign low_mask = (MARK_W'(1) << from_r[BIT_W:1]) - MARK_W'(1);
  assign masked   = rd_data_r | low_mask;

  always_comb begin
    zero_found = 1'b0;
    zero_idx   = '0;
    for (int i = MARK_W - 1; i >= 0; i--) begin
      if (!masked[i]) begin
        zero_found = 1'b1;
        zero_idx   = BIT_W'(i);
      end
    end
  end

  assign cand = {from_r[NW-1:WORD_SH], zero_idx, 1'b1};

  always_comb begin
    sts.clr_last    = (addr_r == clr_end);
    sts.from_ge_lim = (from_r >= lim_r);
    sts.chk_hit     = zero_found && (cand < lim_r);
    sts.chk_none    = !zero_found;
    sts.sq_lt_lim   = (sq_r < (2*NW)'(lim_r));
    sts.m_ge_lim    = (m_r >= lim_r);
    sts.two_pend    = two_pend_r;
    sts.exh         = exh_r;
    sts.lim_le2     = lim_le2;
  end

  // mark memory port control
  always_comb begin
    rd_addr = (cmd.op == OP_STRIKE_RD) ? m_word : from_word;
    wr_en   = 1'b0;
    wr_addr = addr_r;
    wr_data = '0;
    if (cmd.op == OP_CLR_STEP) begin
      wr_en = 1'b1;
    end else if (cmd.op == OP_STRIKE_WR) begin
      wr_en   = 1'b1;
      wr_addr = m_word;
      wr_data = rd_data_r | (MARK_W'(1) << m_r[BIT_W:1]);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lim_r      <= NW'(LIM_RST);
      two_pend_r <= 1'b1;
      exh_r      <= 1'b0;
      strobe_r   <= 1'b0;
    end else begin
      strobe_r <= 1'b0;
      if (cfg_we) begin
        lim_r <= lim_nxt;
      end
      unique case (cmd.op)
        OP_BUILD_DONE: begin
          two_pend_r <= 1'b1;
          exh_r      <= 1'b0;
        end
        OP_REQ_INIT:  two_pend_r <= 1'b0;
        OP_EMIT_NONE: strobe_r <= 1'b1;
        OP_EMIT_HIT:  strobe_r <= 1'b1;
        OP_EMIT_MISS: begin
          strobe_r <= 1'b1;
          exh_r    <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // payload
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_CLR_START: addr_r <= '0;
      OP_CLR_STEP:  addr_r <= addr_r + AW'(1);
      OP_FROM3:     from_r <= NW'(3);
      OP_FIND_CHK: begin
        if (zero_found) begin
          from_r <= cand;
        end else begin
          from_r <= {from_r[NW-1:WORD_SH] + (NW - WORD_SH)'(1), WORD_SH'(1)};
        end
      end
      OP_SQ: sq_r <= from_r * from_r;
      OP_STRIKE_INIT: begin
        p_r <= from_r;
        m_r <= from_r + (from_r << 1);
      end
      OP_STRIKE_WR: m_r <= m_r + (p_r << 1);
      OP_NEXT_P:    from_r <= p_r + NW'(2);
      OP_REQ_INIT: begin
        from_r <= two_pend_r ? NW'(3) : next_r + NW'(2);
        e_r    <= two_pend_r ? NW'(2) : next_r;
      end
      OP_EMIT_NONE: begin
        prime_r <= '0;
        valid_r <= 1'b0;
        last_r  <= 1'b0;
      end
      OP_EMIT_HIT: begin
        prime_r <= e_r[VALUE_W-1:0];
        valid_r <= 1'b1;
        last_r  <= 1'b0;
        next_r  <= from_r;
      end
      OP_EMIT_MISS: begin
        prime_r <= e_r[VALUE_W-1:0];
        valid_r <= 1'b1;
        last_r  <= 1'b1;
      end
      default: ;
    endcase
  end

  assign out_strobe      = strobe_r;
  assign out_prime_value = prime_r;
  assign out_valid_res   = valid_r;
  assign out_last        = last_r;

endmodule

// ===== design/ops_ctrl.sv =====
// ----------------------------------------------------------------------------
// ops_ctrl
// Sieve controller: sequences clearing, sieving, the next-unmarked search
// and result delivery by issuing datapath opcodes.
// ----------------------------------------------------------------------------
module ops_ctrl import ops_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic start_acc,
  input  logic in_restart,
  input  logic cfg_we,
  input  sts_t sts,
  output cmd_t cmd,
  output logic busy
);

  localparam int SW = 4;
  localparam logic [SW-1:0] ST_IDLE  = 4'd0;
  localparam logic [SW-1:0] ST_CLR   = 4'd1;
  localparam logic [SW-1:0] ST_BPI   = 4'd2;
  localparam logic [SW-1:0] ST_FRD   = 4'd3;
  localparam logic [SW-1:0] ST_FCHK  = 4'd4;
  localparam logic [SW-1:0] ST_SQ    = 4'd5;
  localparam logic [SW-1:0] ST_SQCHK = 4'd6;
  localparam logic [SW-1:0] ST_SRD   = 4'd7;
  localparam logic [SW-1:0] ST_SWR   = 4'd8;
  localparam logic [SW-1:0] ST_BDONE = 4'd9;
  localparam logic [SW-1:0] ST_DISP  = 4'd10;
  localparam logic [SW-1:0] ST_EHIT  = 4'd11;
  localparam logic [SW-1:0] ST_EMISS = 4'd12;

  logic [SW-1:0] state_r, state_nxt;
  logic          built_r, built_nxt;
  logic          bld_r, bld_nxt;

  always_comb begin
    state_nxt = state_r;
    built_nxt = built_r;
    bld_nxt   = bld_r;
    cmd.op    = OP_NOP;
    unique case (state_r)
      ST_IDLE: begin
        if (cfg_we) begin
          built_nxt = 1'b0;
        end
        if (start_acc) begin
          if (in_restart || !built_r || cfg_we) begin
            cmd.op    = OP_CLR_START;
            built_nxt = 1'b0;
            state_nxt = ST_CLR;
          end else begin
            state_nxt = ST_DISP;
          end
        end
      end
      ST_CLR: begin
        cmd.op = OP_CLR_STEP;
        if (sts.clr_last) begin
          state_nxt = ST_BPI;
        end
      end
      ST_BPI: begin
        cmd.op    = OP_FROM3;
        bld_nxt   = 1'b1;
        state_nxt = ST_FRD;
      end
      ST_FRD: begin
        if (sts.from_ge_lim) begin
          state_nxt = bld_r ? ST_BDONE : ST_EMISS;
        end else begin
          cmd.op    = OP_FIND_RD;
          state_nxt = ST_FCHK;
        end
      end
      ST_FCHK: begin
        cmd.op = OP_FIND_CHK;
        if (sts.chk_hit) begin
          state_nxt = bld_r ? ST_SQ : ST_EHIT;
        end else if (sts.chk_none) begin
          state_nxt = ST_FRD;
        end else begin
          state_nxt = bld_r ? ST_BDONE : ST_EMISS;
        end
      end
      ST_SQ: begin
        cmd.op    = OP_SQ;
        state_nxt = ST_SQCHK;
      end
      ST_SQCHK: begin
        if (sts.sq_lt_lim) begin
          cmd.op    = OP_STRIKE_INIT;
          state_nxt = ST_SRD;
        end else begin
          state_nxt = ST_BDONE;
        end
      end
      ST_SRD: begin
        if (sts.m_ge_lim) begin
          cmd.op    = OP_NEXT_P;
          state_nxt = ST_FRD;
        end else begin
          cmd.op    = OP_STRIKE_RD;
          state_nxt = ST_SWR;
        end
      end
      ST_SWR: begin
        cmd.op    = OP_STRIKE_WR;
        state_nxt = ST_SRD;
      end
      ST_BDONE: begin
        cmd.op    = OP_BUILD_DONE;
        built_nxt = 1'b1;
        state_nxt = ST_DISP;
      end
      ST_DISP: begin
        if ((sts.two_pend && sts.lim_le2) || (!sts.two_pend && sts.exh)) begin
          cmd.op    = OP_EMIT_NONE;
          state_nxt = ST_IDLE;
        end else begin
          cmd.op    = OP_REQ_INIT;
          bld_nxt   = 1'b0;
          state_nxt = ST_FRD;
        end
      end
      ST_EHIT: begin
        cmd.op    = OP_EMIT_HIT;
        state_nxt = ST_IDLE;
      end
      ST_EMISS: begin
        cmd.op    = OP_EMIT_MISS;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      built_r <= 1'b0;
      bld_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      built_r <= built_nxt;
      bld_r   <= bld_nxt;
    end
  end

  assign busy = (state_r != ST_IDLE);

endmodule

// ===== design/odd_only_prime_sieve_core.sv =====
// ----------------------------------------------------------------------------
// odd_only_prime_sieve_core
// Odd-only Sieve of Eratosthenes: returns the primes below a configured
// limit in ascending order, one beat per request.
// With a built sieve a request scans the mark memory from the last prime on,
// reading and checking one 32-mark word at a time; once no primes remain it
// answers with an empty beat and no scan. A rebuild first clears the words up
// to the limit, then finds each sieving prime and strikes its multiples.
// Throughput: one request at a time; start is taken only while busy is low.
// Reset: synchronous; no clearing pass, the first request builds the sieve.
// Results are a one-cycle strobe; the receiver cannot stall.
// ----------------------------------------------------------------------------
module odd_only_prime_sieve_core import ops_pkg::*; #(
  parameter int MAX_LIMIT = DEF_MAX_LIMIT
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_restart,
  output logic               out_strobe,
  output logic [VALUE_W-1:0] out_prime_value,
  output logic               out_valid_res,
  output logic               out_last,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [LIMIT_W-1:0] cfg_upper_limit
);

  cmd_t cmd;
  sts_t sts;
  logic start_acc;
  logic cfg_we;

  assign cfg_ready = ~busy;
  assign cfg_we    = cfg_valid & cfg_ready;
  assign start_acc = start & ~busy;

  ops_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start_acc  (start_acc),
    .in_restart (in_restart),
    .cfg_we     (cfg_we),
    .sts        (sts),
    .cmd        (cmd),
    .busy       (busy)
  );

  ops_dp #(
    .MAX_LIMIT (MAX_LIMIT)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .cfg_we          (cfg_we),
    .cfg_upper_limit (cfg_upper_limit),
    .out_strobe      (out_strobe),
    .out_prime_value (out_prime_value),
    .out_valid_res   (out_valid_res),
    .out_last        (out_last)
  );

  a_strobe_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(busy))
    else $error("result beat without preceding work");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("result beat repeated");

  a_exhausted_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_valid_res) |-> (out_prime_value == '0) && !out_last)
    else $error("exhausted beat carries data");

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted request did not start work");

endmodule
